>>> src/sccc_pkg.sv
// Shared constants, state codes and result type for the snooping cache controller.
package sccc_pkg;
   localparam int Sets = 256;
   localparam int Ways = 8;
   localparam int BlockBytes = 64;
   localparam int AddrBits = 32;
   localparam int OffBits = $clog2(BlockBytes);
   localparam int SetBits = $clog2(Sets);
   localparam int WayBits = (Ways > 1) ? $clog2(Ways) : 1;
   localparam int TagBits = AddrBits - OffBits - SetBits;
   localparam int AgeBits = WayBits;

   localparam logic [2:0] ST_I  = 3'd0;
   localparam logic [2:0] ST_S  = 3'd1;
   localparam logic [2:0] ST_E  = 3'd2;
   localparam logic [2:0] ST_M  = 3'd3;
   localparam logic [2:0] ST_SC = 3'd4;
   localparam logic [2:0] ST_SM = 3'd5;

   localparam logic [2:0] OP_PR_RD  = 3'd0;
   localparam logic [2:0] OP_PR_WR  = 3'd1;
   localparam logic [2:0] OP_SN_RD  = 3'd2;
   localparam logic [2:0] OP_SN_RDX = 3'd3;
   localparam logic [2:0] OP_SN_UPD = 3'd4;

   localparam logic [1:0] PROT_MSI    = 2'd0;
   localparam logic [1:0] PROT_MESI   = 2'd1;
   localparam logic [1:0] PROT_DRAGON = 2'd2;

   localparam logic [1:0] BUS_NONE = 2'd0;
   localparam logic [1:0] BUS_RD   = 2'd1;
   localparam logic [1:0] BUS_RDX  = 2'd2;
   localparam logic [1:0] BUS_UPD  = 2'd3;

   // One way of a set as held in the set memory.
   typedef struct packed {
      logic [TagBits-1:0] tag;
      logic [2:0]         st;
      logic [AgeBits-1:0] age;
   } way_type;

   typedef way_type [Ways-1:0] set_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] line_state;
      logic [1:0] bus_request;
      logic       victim_writeback;
      logic       snoop_flush;
      logic       intervention;
      logic       invalidated;
      logic       cache_transfer;
      logic [1:0] memory_transactions;
   } rsp_type;
endpackage

>>> src/sccc_set_mem.sv
// Set memory: one word per set holding all ways, with a valid bit per set.
module sccc_set_mem import sccc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [SetBits-1:0] rd_addr,
   output set_type            rd_data,
   input  logic               wr_en,
   input  logic [SetBits-1:0] wr_addr,
   input  set_type            wr_data
);
   set_type        mem [Sets];
   set_type        raw_ff;
   logic           vld_ff, vld_in;
   logic           fwd;
   logic [Sets-1:0] set_vld_ff;

   // A read of the set being written in the same cycle takes the new data.
   assign fwd = wr_en && (wr_addr == rd_addr);

   // Memory array with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         raw_ff <= fwd ? wr_data : mem[rd_addr];
      end
   end

   // Sets never written read as invalid ways of age zero.
   assign vld_in = set_vld_ff[rd_addr] || fwd;
   always_ff @(posedge clock) begin
      if (reset) begin
         set_vld_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            set_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            vld_ff <= vld_in;
         end
      end
   end

   always_comb begin
      rd_data = raw_ff;
      if (!vld_ff) begin
         for (int w = 0; w < Ways; w++) begin
            rd_data[w].st = ST_I;
            rd_data[w].age = '0;
         end
      end
   end
endmodule

>>> src/sccc_update.sv
// Lookup, victim choice, protocol transitions and age update for one set.
module sccc_update import sccc_pkg::*; (
   input  logic [1:0]         protocol,
   input  logic [2:0]         op,
   input  logic [TagBits-1:0] tag,
   input  logic               shared,
   input  logic               flushed,
   input  set_type            set_in,
   output set_type            set_out,
   output logic               wr_en,
   output rsp_type            rsp
);
   logic [WayBits-1:0] hway, vway, iway, lway, uway;
   logic               hit, anyinv, touch;
   logic [2:0]         st, vst;
   logic [AgeBits-1:0] best, old;
   logic [1:0]         mem;
   logic               wr, rd;

   always_comb begin
      hit = 1'b0; hway = '0; anyinv = 1'b0; iway = '0; lway = '0; best = '0;
      old = '0;
      for (int w = Ways - 1; w >= 0; w--) begin
         if (set_in[w].st != ST_I && set_in[w].tag == tag) begin
            hit = 1'b1; hway = WayBits'(w);
         end
         if (set_in[w].st == ST_I) begin
            anyinv = 1'b1; iway = WayBits'(w);
         end
      end
      // Largest age, last way on ties.
      for (int w = 0; w < Ways; w++) begin
         if (w == 0 || set_in[w].age >= best) begin
            lway = WayBits'(w); best = set_in[w].age;
         end
      end
      vway = anyinv ? iway : lway;
      vst = set_in[vway].st;

      rsp = '0; set_out = set_in; wr_en = 1'b0; touch = 1'b0;
      wr = (op == OP_PR_WR); rd = (op == OP_SN_RD);
      st = hit ? set_in[hway].st : ST_I;
      uway = hit ? hway : vway;
      mem = 2'd0;
      rsp.hit = hit;

      if (op > OP_SN_UPD) begin
         rsp = '0; st = ST_I;
      end else if (protocol > PROT_DRAGON) begin
         // Lookup only.
      end else if (op <= OP_PR_WR) begin
         wr_en = 1'b1; touch = 1'b1;
         if (!hit) begin
            if (vst == ST_M || vst == ST_SM) begin
               rsp.victim_writeback = 1'b1; mem = mem + 2'd1;
            end
            set_out[vway].tag = tag;
            if (protocol == PROT_MSI) begin
               rsp.bus_request = wr ? BUS_RDX : BUS_RD;
               st = wr ? ST_M : ST_S;
               mem = mem + 2'd1;
            end else if (protocol == PROT_MESI) begin
               rsp.bus_request = wr ? BUS_RDX : BUS_RD;
               st = wr ? ST_M : (shared ? ST_S : ST_E);
               if (flushed) rsp.cache_transfer = 1'b1;
               else mem = mem + 2'd1;
            end else begin
               rsp.bus_request = (wr && shared) ? BUS_UPD : BUS_RD;
               if (wr) st = shared ? ST_SM : ST_M;
               else st = shared ? ST_SC : ST_E;
               mem = mem + 2'd1;
            end
         end else if (wr) begin
            if (protocol == PROT_MSI) begin
               if (st == ST_S) begin
                  rsp.bus_request = BUS_RDX; mem = mem + 2'd1;
               end
               st = ST_M;
            end else if (protocol == PROT_MESI) begin
               if (st == ST_S) rsp.bus_request = BUS_UPD;
               st = ST_M;
            end else if (st == ST_SM || st == ST_SC) begin
               rsp.bus_request = BUS_UPD;
               st = shared ? ST_SM : ST_M;
            end else begin
               st = ST_M;
            end
         end
         set_out[uway].st = st;
      end else if (hit) begin
         wr_en = 1'b1;
         if (protocol == PROT_MSI) begin
            if (st == ST_M) begin
               rsp.snoop_flush = 1'b1; mem = mem + 2'd1; rsp.intervention = rd;
            end
            if (rd) st = ST_S;
            else begin
               st = ST_I; rsp.invalidated = 1'b1;
            end
         end else if (protocol == PROT_MESI) begin
            if (st == ST_M) begin
               rsp.snoop_flush = 1'b1; mem = mem + 2'd1; rsp.intervention = rd;
            end else if (st == ST_E) begin
               rsp.snoop_flush = 1'b1; rsp.intervention = rd;
            end else if (st == ST_S) begin
               rsp.snoop_flush = (op != OP_SN_UPD);
            end
            if (rd) st = ST_S;
            else begin
               st = ST_I; rsp.invalidated = 1'b1;
            end
         end else begin
            if (st == ST_M) begin
               st = ST_SM; rsp.intervention = 1'b1; rsp.snoop_flush = 1'b1;
            end else if (st == ST_E) begin
               st = ST_SC; rsp.intervention = 1'b1;
            end else if (st == ST_SM) begin
               if (op == OP_SN_UPD) st = ST_SC;
               else rsp.snoop_flush = 1'b1;
            end
         end
         set_out[hway].st = st;
      end

      // Age order update for the touched way.
      if (touch) begin
         old = set_in[uway].age;
         for (int w = 0; w < Ways; w++) begin
            if (WayBits'(w) != uway && set_in[w].age <= old &&
                set_in[w].age < AgeBits'(Ways - 1)) begin
               set_out[w].age = set_in[w].age + 1'b1;
            end
         end
         set_out[uway].age = '0;
      end

      rsp.line_state = st;
      rsp.memory_transactions = mem;
   end
endmodule

>>> src/snooping_coherent_cache_controller_top.sv
// Top level of the snooping coherent cache controller.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | op, addr, others_hold_copy, flush_seen
//   rsp     | out       | rsp_valid/stall    | hit, line_state, bus_request, flags, count
//   csr     | in        | csr_write_enable   | protocol
//
// A transfer reads its set from the set memory, then updates and writes the set
// back in the update stage, which also loads the result into the output register.
// The next request is read while the previous one writes
// back, so without output stalls one item per cycle is taken. While a result
// waits in the output register one more request is held in the update stage
// and further requests stall. Reset is synchronous and immediate.
module snooping_coherent_cache_controller_top import sccc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_op,
   input  logic [31:0]         req_addr,
   input  logic                req_others_hold_copy,
   input  logic                req_flush_seen,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [2:0]          rsp_line_state,
   output logic [1:0]          rsp_bus_request,
   output logic                rsp_victim_writeback,
   output logic                rsp_snoop_flush,
   output logic                rsp_intervention,
   output logic                rsp_invalidated,
   output logic                rsp_cache_transfer,
   output logic [1:0]          rsp_memory_transactions,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_write_data
);
   logic [1:0]         protocol_ff;
   logic               busy_ff;
   logic [2:0]         op_ff;
   logic [TagBits-1:0] tag_ff;
   logic [SetBits-1:0] idx_ff;
   logic               sh_ff, fl_ff;
   logic               out_vld_ff;
   rsp_type            out_ff, rsp_in;
   set_type            set_rd, set_wr;
   logic               upd_wr, accept, finish;
   logic [SetBits-1:0] req_idx;

   assign req_idx = req_addr[OffBits +: SetBits];
   // Stage two finishes once the output register is free or leaving.
   assign finish = busy_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = busy_ff && !finish;
   assign accept = req_valid && !req_stall;

   sccc_set_mem u_mem (
      .clock(clock), .reset(reset),
      .rd_en(accept), .rd_addr(req_idx), .rd_data(set_rd),
      .wr_en(finish && upd_wr), .wr_addr(idx_ff), .wr_data(set_wr)
   );

   sccc_update u_upd (
      .protocol(protocol_ff), .op(op_ff), .tag(tag_ff), .shared(sh_ff),
      .flushed(fl_ff), .set_in(set_rd), .set_out(set_wr), .wr_en(upd_wr),
      .rsp(rsp_in)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_ff <= PROT_MSI;
         busy_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_write_enable) protocol_ff <= csr_write_data;
         if (accept) busy_ff <= 1'b1;
         else if (finish) busy_ff <= 1'b0;
         if (finish) out_vld_ff <= 1'b1;
         else if (!rsp_stall) out_vld_ff <= 1'b0;
      end
   end

   // Request capture and result register. A back-to-back access to the same
   // set gets the set being written back through forwarding in the set memory.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_op;
         tag_ff <= req_addr[AddrBits-1 -: TagBits];
         idx_ff <= req_idx;
         sh_ff <= req_others_hold_copy;
         fl_ff <= req_flush_seen;
      end
      if (finish) out_ff <= rsp_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_hit = out_ff.hit;
   assign rsp_line_state = out_ff.line_state;
   assign rsp_bus_request = out_ff.bus_request;
   assign rsp_victim_writeback = out_ff.victim_writeback;
   assign rsp_snoop_flush = out_ff.snoop_flush;
   assign rsp_intervention = out_ff.intervention;
   assign rsp_invalidated = out_ff.invalidated;
   assign rsp_cache_transfer = out_ff.cache_transfer;
   assign rsp_memory_transactions = out_ff.memory_transactions;
endmodule

>>> tb/tb_snooping_coherent_cache_controller_checker.sv
// Checker for the snooping cache controller: predicts each result and compares it.
module tb_snooping_coherent_cache_controller_checker import sccc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_addr,
   input  logic        req_others_hold_copy,
   input  logic        req_flush_seen,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_actual,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [TagBits-1:0] tag_mem [Sets*Ways];
   logic [2:0]         state_mem [Sets*Ways];
   int                 age_mem [Sets*Ways];
   logic [1:0]         protocol_sel;
   rsp_type            expected_rsp_q [$];

   // Moves the touched way to most recent and ages the younger ways.
   function automatic void touch_way(int base, int w);
      int old_age;
      old_age = age_mem[base + w];
      for (int j = 0; j < Ways; j++)
         if (j != w && age_mem[base + j] <= old_age && age_mem[base + j] < Ways - 1)
            age_mem[base + j]++;
      age_mem[base + w] = 0;
   endfunction

   // Computes the result of one access and updates the predicted cache.
   function automatic rsp_type predict_access(logic [2:0] op, logic [31:0] addr,
                                              logic shared, logic flushed);
      rsp_type r;
      int base, way, victim, best;
      logic [TagBits-1:0] tag;
      logic [2:0] st;
      logic wr, rd;
      r = '0;
      base = int'(addr[OffBits +: SetBits]) * Ways;
      tag = addr[31 -: TagBits];
      way = Ways;
      st = ST_I;
      if (op > OP_SN_UPD) return r;
      for (int w = 0; w < Ways; w++)
         if (way == Ways && state_mem[base + w] != ST_I && tag_mem[base + w] == tag) way = w;
      if (way < Ways) begin
         r.hit = 1'b1;
         st = state_mem[base + way];
      end
      if (protocol_sel > PROT_DRAGON) begin
         // Lookup only.
      end else if (op <= OP_PR_WR) begin
         wr = (op == OP_PR_WR);
         if (!r.hit) begin
            victim = Ways;
            best = 0;
            for (int w = 0; w < Ways; w++)
               if (victim == Ways && state_mem[base + w] == ST_I) victim = w;
            if (victim == Ways) begin
               for (int w = 0; w < Ways; w++)
                  if (victim == Ways || age_mem[base + w] >= best) begin
                     victim = w;
                     best = age_mem[base + w];
                  end
            end
            if (state_mem[base + victim] == ST_M || state_mem[base + victim] == ST_SM) begin
               r.victim_writeback = 1'b1;
               r.memory_transactions++;
            end
            touch_way(base, victim);
            tag_mem[base + victim] = tag;
            way = victim;
            if (protocol_sel == PROT_MSI) begin
               r.bus_request = wr ? BUS_RDX : BUS_RD;
               st = wr ? ST_M : ST_S;
               r.memory_transactions++;
            end else if (protocol_sel == PROT_MESI) begin
               r.bus_request = wr ? BUS_RDX : BUS_RD;
               st = wr ? ST_M : (shared ? ST_S : ST_E);
               if (flushed) r.cache_transfer = 1'b1;
               else r.memory_transactions++;
            end else begin
               r.bus_request = (wr && shared) ? BUS_UPD : BUS_RD;
               if (wr) st = shared ? ST_SM : ST_M;
               else st = shared ? ST_SC : ST_E;
               r.memory_transactions++;
            end
         end else begin
            touch_way(base, way);
            if (wr) begin
               if (protocol_sel == PROT_MSI) begin
                  if (st == ST_S) begin
                     r.bus_request = BUS_RDX;
                     r.memory_transactions++;
                  end
                  st = ST_M;
               end else if (protocol_sel == PROT_MESI) begin
                  if (st == ST_S) r.bus_request = BUS_UPD;
                  st = ST_M;
               end else if (st == ST_SM || st == ST_SC) begin
                  r.bus_request = BUS_UPD;
                  st = shared ? ST_SM : ST_M;
               end else begin
                  st = ST_M;
               end
            end
         end
         state_mem[base + way] = st;
      end else if (r.hit) begin
         rd = (op == OP_SN_RD);
         if (protocol_sel == PROT_MSI) begin
            if (st == ST_M) begin
               r.snoop_flush = 1'b1;
               r.memory_transactions++;
               r.intervention = rd;
            end
            if (rd) st = ST_S;
            else begin
               st = ST_I;
               r.invalidated = 1'b1;
            end
         end else if (protocol_sel == PROT_MESI) begin
            if (st == ST_M) begin
               r.snoop_flush = 1'b1;
               r.memory_transactions++;
               r.intervention = rd;
            end else if (st == ST_E) begin
               r.snoop_flush = 1'b1;
               r.intervention = rd;
            end else if (st == ST_S && op != OP_SN_UPD) r.snoop_flush = 1'b1;
            if (rd) st = ST_S;
            else begin
               st = ST_I;
               r.invalidated = 1'b1;
            end
         end else begin
            if (st == ST_M) begin
               st = ST_SM;
               r.intervention = 1'b1;
               r.snoop_flush = 1'b1;
            end else if (st == ST_E) begin
               st = ST_SC;
               r.intervention = 1'b1;
            end else if (st == ST_SM) begin
               if (op == OP_SN_UPD) st = ST_SC;
               else r.snoop_flush = 1'b1;
            end
         end
         state_mem[base + way] = st;
      end
      r.line_state = st;
      return r;
   endfunction

   assign pending_count = expected_rsp_q.size();

   // Predicts on each request transfer and compares on each result transfer.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         for (int i = 0; i < Sets*Ways; i++) begin
            tag_mem[i] = '0;
            state_mem[i] = ST_I;
            age_mem[i] = 0;
         end
         protocol_sel = PROT_MSI;
         expected_rsp_q.delete();
         fail_count = 0;
      end else begin
         if (csr_write_enable) protocol_sel = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               if (fail_count < 10) $display("ERROR: result with none expected: %p", rsp_actual);
               fail_count = fail_count + 1;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (exp_rsp !== rsp_actual) begin
                  if (fail_count < 10)
                     $display("ERROR: mismatch expected %p actual %p", exp_rsp, rsp_actual);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(predict_access(req_op, req_addr,
                                                    req_others_hold_copy, req_flush_seen));
      end
   end
endmodule

>>> tb/tb_snooping_coherent_cache_controller_top.sv
// Testbench top for the snooping cache controller: stimulus, stalls and verdict.
module tb_snooping_coherent_cache_controller_top import sccc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = OP_PR_RD;
   logic [31:0] req_addr = '0;
   logic        req_others_hold_copy = 1'b0;
   logic        req_flush_seen = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_actual;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_write_data = PROT_MSI;
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   bit          long_hold = 1'b0;
   bit          stimulus_done = 1'b0;

   snooping_coherent_cache_controller_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_addr(req_addr), .req_others_hold_copy(req_others_hold_copy),
      .req_flush_seen(req_flush_seen),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_hit(rsp_actual.hit), .rsp_line_state(rsp_actual.line_state),
      .rsp_bus_request(rsp_actual.bus_request),
      .rsp_victim_writeback(rsp_actual.victim_writeback),
      .rsp_snoop_flush(rsp_actual.snoop_flush),
      .rsp_intervention(rsp_actual.intervention),
      .rsp_invalidated(rsp_actual.invalidated),
      .rsp_cache_transfer(rsp_actual.cache_transfer),
      .rsp_memory_transactions(rsp_actual.memory_transactions),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   tb_snooping_coherent_cache_controller_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_addr(req_addr), .req_others_hold_copy(req_others_hold_copy),
      .req_flush_seen(req_flush_seen),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_actual(rsp_actual),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   // Offers one request and holds it until the transfer happens.
   task automatic send_access(logic [2:0] op, logic [31:0] addr, logic shared, logic flushed);
      req_valid <= 1'b1;
      req_op <= op;
      req_addr <= addr;
      req_others_hold_copy <= shared;
      req_flush_seen <= flushed;
      do @(posedge clock); while (req_stall);
   endtask

   // Drops valid and waits a number of cycles.
   task automatic idle_gap(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Waits for all results, lets the pipeline drain and writes the protocol.
   task automatic set_protocol(logic [1:0] value);
      idle_gap(1);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Builds an address from a small tag pool so that sets fill and hits recur.
   function automatic logic [31:0] pool_addr(int set_span, int tag_span);
      logic [31:0] a;
      a = $urandom();
      a[OffBits +: SetBits] = SetBits'($urandom_range(set_span - 1));
      a[31 -: TagBits] = TagBits'($urandom_range(tag_span - 1));
      if ($urandom_range(15) == 0) a[31 -: TagBits] = ~a[31 -: TagBits];
      return a;
   endfunction

   // Receiver stall pattern, with a long hold-off when requested.
   always @(posedge clock) begin
      if (long_hold) rsp_stall <= 1'b1;
      else if (($urandom_range(99) < 30) && ($urandom_range(3) != 0)) rsp_stall <= 1'b1;
      else rsp_stall <= 1'b0;
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || long_hold)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Stimulus and verdict.
   initial begin
      logic [1:0] prot_list [5];
      logic [2:0] op;
      int burst;
      prot_list = '{PROT_MSI, PROT_MESI, PROT_DRAGON, 2'd3, PROT_MESI};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill one set past its ways, every op, extremes of the address.
      set_protocol(PROT_DRAGON);
      for (int i = 0; i < 9; i++)
         send_access(i[0] ? OP_PR_WR : OP_PR_RD, {TagBits'(i), 8'd3, 6'd0}, i[1], i[2]);
      send_access(OP_PR_WR, {TagBits'(1), 8'd3, 6'd0}, 1'b1, 1'b0);
      send_access(OP_SN_RD, {TagBits'(2), 8'd3, 6'd0}, 1'b0, 1'b0);
      send_access(OP_SN_RDX, {TagBits'(3), 8'd3, 6'd0}, 1'b0, 1'b0);
      send_access(OP_SN_UPD, {TagBits'(5), 8'd3, 6'd0}, 1'b0, 1'b0);
      send_access(3'd5, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_access(3'd7, 32'h0, 1'b0, 1'b0);
      send_access(OP_PR_WR, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_access(OP_PR_RD, 32'h0000_0000, 1'b0, 1'b0);
      set_protocol(PROT_MSI);
      send_access(OP_SN_UPD, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_access(OP_PR_WR, {TagBits'(2), 8'd3, 6'd0}, 1'b0, 1'b0);
      send_access(OP_SN_RD, {TagBits'(2), 8'd3, 6'd0}, 1'b0, 1'b0);

      // Random phases over all protocol settings.
      for (int phase = 0; phase < 5; phase++) begin
         set_protocol(prot_list[phase]);
         for (int n = 0; n < 350; n += burst) begin
            burst = $urandom_range(12, 1);
            if (phase == 2 && n == 0) begin
               long_hold <= 1'b1;
               fork
                  begin
                     repeat (60) @(posedge clock);
                     long_hold <= 1'b0;
                  end
               join_none
            end
            for (int k = 0; k < burst; k++) begin
               op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                             : 3'($urandom_range(4));
               send_access(op, pool_addr(4, 12), $urandom_range(1), $urandom_range(1));
            end
            if ($urandom_range(3) != 0) idle_gap($urandom_range(6));
         end
      end

      idle_gap(1);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
